// ===== design/rrsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsc_pkg: shared constants and types for the running regression unit
// Sample and count widths, divider and root sizes, fixed-point scales,
// sequencer states and the order of the serial products.
// ----------------------------------------------------------------------------
package rrsc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;

  // quotient bits produced by the shared divider
  localparam int DIV_QB      = 32;
  // bits of the integer square root result
  localparam int ROOT_BITS   = 16;

  // slope is Q.12, correlation is Q1.14 (square taken inside the root)
  localparam int SLOPE_FRAC  = 12;
  localparam int CORR_SHIFT  = 28;
  localparam logic [ROOT_BITS-1:0] CORR_ONE = 16'd16384;

  localparam logic [31:0] SLOPE_NEG_LIM = 32'h8000_0000;
  localparam logic [31:0] SLOPE_POS_LIM = 32'h7fff_ffff;

  // serial products in the order the sequencer runs them
  typedef enum logic [3:0] {
    MS_XX,
    MS_YY,
    MS_XY,
    MS_NXY,
    MS_SXSY,
    MS_NXX,
    MS_SXSX,
    MS_NYY,
    MS_SYSY,
    MS_DXDY,
    MS_NUMSQ
  } mul_step_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_RUN,
    ST_DIVS_GO,
    ST_DIVS_RUN,
    ST_DIVC_GO,
    ST_DIVC_RUN,
    ST_SQRT_GO,
    ST_SQRT_RUN,
    ST_DONE
  } state_e;

endpackage

// ===== design/running_regression_slope_corr_unit.sv =====
// ----------------------------------------------------------------------------
// running_regression_slope_corr_unit: running least-squares slope and
// Pearson correlation over (x, y) sample pairs
// Keeps count and exact sums; reports slope Q.12 and correlation Q1.14.
// ----------------------------------------------------------------------------
// One request is processed at a time. The bit-serial multiplier runs eleven
// products in turn (three sample squares and cross terms, six count/sum cross
// terms, dx*dy and num*num); the three sample products are skipped once the
// count is full. A 32-bit restoring divider then forms the slope and the
// correlation ratio, and the root follows. An item finishes sooner with small
// operands; a non-positive denominator skips its divide. The next request is
// taken while a result waits in the output register. Once the count is at its
// maximum, samples leave the sums alone and count_full is set.
// ----------------------------------------------------------------------------
module running_regression_slope_corr_unit #(
  parameter int SAMPLE_BITS = rrsc_pkg::SAMPLE_BITS,
  parameter int COUNT_BITS  = rrsc_pkg::COUNT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_x_i,
  input  logic signed [15:0] sample_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        sample_count_o,
  output logic signed [31:0] slope_o,
  output logic               slope_valid_o,
  output logic signed [15:0] correlation_o,
  output logic               correlation_valid_o,
  output logic               count_full_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int CB = COUNT_BITS;
  localparam int SW = SB + CB;
  localparam int QW = 2*SB + CB;
  localparam int MW = 2*SB + 2*CB;
  localparam int OW = MW + 1;
  localparam int PW = 2*MW + 2;
  localparam int DW = 2*MW + rrsc_pkg::DIV_QB + 1;
  localparam int QB = rrsc_pkg::DIV_QB;
  localparam int RB = rrsc_pkg::ROOT_BITS;

  localparam logic [QB-1:0] SLOPE_NEG = rrsc_pkg::SLOPE_NEG_LIM;
  localparam logic [QB-1:0] SLOPE_POS = rrsc_pkg::SLOPE_POS_LIM;

  rrsc_pkg::state_e    state_q, state_d;
  rrsc_pkg::mul_step_e step_q;

  logic signed [SB-1:0] x_in, y_in, x_q, y_q;
  logic [CB-1:0]        cnt_q;
  logic signed [SW-1:0] sum_x_q, sum_y_q;
  logic signed [QW-1:0] sum_xx_q, sum_yy_q, sum_xy_q;
  logic signed [OW-1:0] t1_q, num_q, dx_q, dy_q, nval;
  logic [2*MW-1:0]      dd_q, nsq_q;
  logic signed [31:0]   slope_q, slope_d;
  logic [QB-1:0]        rt_q, qs;
  logic signed [15:0]   corr_q, corr_d;
  logic [RB-1:0]        root, rc;
  logic [MW-1:0]        nabs;

  logic accept, room, sv, cv, num_neg, out_load;
  logic mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
  logic signed [OW-1:0] op_a, op_b;
  logic signed [PW-1:0] mul_p;
  logic [DW-1:0]        div_num, div_den;
  logic [QB-1:0]        div_quo;

  logic                 out_valid_q;
  logic [15:0]          cnt_out_q;
  logic signed [31:0]   slope_out_q;
  logic signed [15:0]   corr_out_q;
  logic                 sv_out_q, cv_out_q, full_out_q;

  // read the low SAMPLE_BITS bits as two's complement
  assign x_in = $signed(SB'($unsigned(sample_x_i)));
  assign y_in = $signed(SB'($unsigned(sample_y_i)));

  assign room    = cnt_q != '1;
  assign accept  = (state_q == rrsc_pkg::ST_IDLE) && in_valid_i;
  assign nval    = OW'($signed({1'b0, cnt_q}));
  assign sv      = !dx_q[OW-1] && (dx_q != '0);
  assign cv      = sv && !dy_q[OW-1] && (dy_q != '0);
  assign num_neg = num_q[OW-1];
  assign nabs    = num_neg ? MW'(-num_q) : MW'(num_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrsc_pkg::ST_IDLE:     if (in_valid_i) state_d = rrsc_pkg::ST_MUL_GO;
      rrsc_pkg::ST_MUL_GO:   state_d = rrsc_pkg::ST_MUL_RUN;
      rrsc_pkg::ST_MUL_RUN: begin
        if (mul_done) begin
          state_d = (step_q == rrsc_pkg::MS_NUMSQ) ? rrsc_pkg::ST_DIVS_GO
                                                   : rrsc_pkg::ST_MUL_GO;
        end
      end
      rrsc_pkg::ST_DIVS_GO:  state_d = sv ? rrsc_pkg::ST_DIVS_RUN : rrsc_pkg::ST_DIVC_GO;
      rrsc_pkg::ST_DIVS_RUN: if (div_done) state_d = rrsc_pkg::ST_DIVC_GO;
      rrsc_pkg::ST_DIVC_GO:  state_d = cv ? rrsc_pkg::ST_DIVC_RUN : rrsc_pkg::ST_DONE;
      rrsc_pkg::ST_DIVC_RUN: if (div_done) state_d = rrsc_pkg::ST_SQRT_GO;
      rrsc_pkg::ST_SQRT_GO:  state_d = rrsc_pkg::ST_SQRT_RUN;
      rrsc_pkg::ST_SQRT_RUN: if (sqrt_done) state_d = rrsc_pkg::ST_DONE;
      rrsc_pkg::ST_DONE:     if (!out_valid_q || !out_stall_i) state_d = rrsc_pkg::ST_IDLE;
      default:               state_d = rrsc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = state_q != rrsc_pkg::ST_IDLE;
    mul_start  = state_q == rrsc_pkg::ST_MUL_GO;
    div_start  = ((state_q == rrsc_pkg::ST_DIVS_GO) && sv) ||
                 ((state_q == rrsc_pkg::ST_DIVC_GO) && cv);
    sqrt_start = state_q == rrsc_pkg::ST_SQRT_GO;
    out_load   = (state_q == rrsc_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pick multiplier operands for the current product
  always_comb begin
    case (step_q)
      rrsc_pkg::MS_XX:    begin op_a = OW'(x_q);     op_b = OW'(x_q);     end
      rrsc_pkg::MS_YY:    begin op_a = OW'(y_q);     op_b = OW'(y_q);     end
      rrsc_pkg::MS_XY:    begin op_a = OW'(x_q);     op_b = OW'(y_q);     end
      rrsc_pkg::MS_NXY:   begin op_a = OW'(sum_xy_q); op_b = nval;        end
      rrsc_pkg::MS_SXSY:  begin op_a = OW'(sum_x_q); op_b = OW'(sum_y_q); end
      rrsc_pkg::MS_NXX:   begin op_a = OW'(sum_xx_q); op_b = nval;        end
      rrsc_pkg::MS_SXSX:  begin op_a = OW'(sum_x_q); op_b = OW'(sum_x_q); end
      rrsc_pkg::MS_NYY:   begin op_a = OW'(sum_yy_q); op_b = nval;        end
      rrsc_pkg::MS_SYSY:  begin op_a = OW'(sum_y_q); op_b = OW'(sum_y_q); end
      rrsc_pkg::MS_DXDY:  begin op_a = dx_q;         op_b = dy_q;         end
      rrsc_pkg::MS_NUMSQ: begin op_a = num_q;        op_b = num_q;        end
      default:            begin op_a = '0;           op_b = '0;           end
    endcase
  end

  rrsc_mul #(.MW(MW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // select dividend and divisor for slope or correlation
  always_comb begin
    if (state_q == rrsc_pkg::ST_DIVS_GO) begin
      div_num = DW'(nabs) << rrsc_pkg::SLOPE_FRAC;
      div_den = DW'(MW'(dx_q));
    end else begin
      div_num = DW'(nsq_q) << rrsc_pkg::CORR_SHIFT;
      div_den = DW'(dd_q);
    end
  end

  rrsc_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  rrsc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rt_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // saturate slope by sign
  always_comb begin
    if (num_neg) begin
      qs      = (div_quo > SLOPE_NEG) ? SLOPE_NEG : div_quo;
      slope_d = $signed(32'(-{1'b0, qs}));
    end else begin
      qs      = (div_quo > SLOPE_POS) ? SLOPE_POS : div_quo;
      slope_d = $signed(qs);
    end
  end

  // clamp and sign the correlation
  assign rc     = (root > rrsc_pkg::CORR_ONE) ? rrsc_pkg::CORR_ONE : root;
  assign corr_d = num_neg ? -$signed(rc) : $signed(rc);

  // count and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
    end else if (accept && room) begin
      cnt_q   <= cnt_q + 1'b1;
      sum_x_q <= sum_x_q + SW'(x_in);
      sum_y_q <= sum_y_q + SW'(y_in);
    end else if ((state_q == rrsc_pkg::ST_MUL_RUN) && mul_done) begin
      case (step_q)
        rrsc_pkg::MS_XX: sum_xx_q <= sum_xx_q + QW'(mul_p);
        rrsc_pkg::MS_YY: sum_yy_q <= sum_yy_q + QW'(mul_p);
        rrsc_pkg::MS_XY: sum_xy_q <= sum_xy_q + QW'(mul_p);
        default: ;
      endcase
    end
  end

  // step sequence and intermediate results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rrsc_pkg::MS_XX;
    end else if (accept) begin
      step_q <= room ? rrsc_pkg::MS_XX : rrsc_pkg::MS_NXY;
    end else if ((state_q == rrsc_pkg::ST_MUL_RUN) && mul_done) begin
      step_q <= rrsc_pkg::mul_step_e'(step_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= x_in;
      y_q     <= y_in;
      slope_q <= '0;
      corr_q  <= '0;
    end
    if ((state_q == rrsc_pkg::ST_MUL_RUN) && mul_done) begin
      case (step_q)
        rrsc_pkg::MS_NXY,
        rrsc_pkg::MS_NXX,
        rrsc_pkg::MS_NYY:   t1_q  <= OW'(mul_p);
        rrsc_pkg::MS_SXSY:  num_q <= t1_q - OW'(mul_p);
        rrsc_pkg::MS_SXSX:  dx_q  <= t1_q - OW'(mul_p);
        rrsc_pkg::MS_SYSY:  dy_q  <= t1_q - OW'(mul_p);
        rrsc_pkg::MS_DXDY:  dd_q  <= mul_p[2*MW-1:0];
        rrsc_pkg::MS_NUMSQ: nsq_q <= mul_p[2*MW-1:0];
        default: ;
      endcase
    end
    if ((state_q == rrsc_pkg::ST_DIVS_RUN) && div_done) begin
      slope_q <= slope_d;
    end
    if ((state_q == rrsc_pkg::ST_DIVC_RUN) && div_done) begin
      rt_q <= div_quo;
    end
    if ((state_q == rrsc_pkg::ST_SQRT_RUN) && sqrt_done) begin
      corr_q <= corr_d;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cnt_out_q   <= 16'(cnt_q);
      slope_out_q <= slope_q;
      sv_out_q    <= sv;
      corr_out_q  <= corr_q;
      cv_out_q    <= cv;
      full_out_q  <= !room;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sample_count_o      = cnt_out_q;
  assign slope_o             = slope_out_q;
  assign slope_valid_o       = sv_out_q;
  assign correlation_o       = corr_out_q;
  assign correlation_valid_o = cv_out_q;
  assign count_full_o        = full_out_q;

endmodule

// ===== design/rrsc_mul.sv =====
// ----------------------------------------------------------------------------
// rrsc_mul: bit-serial signed multiplier
// Shift-and-add over the magnitude of b, one multiplier bit per cycle; stops
// as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module rrsc_mul #(
  parameter int MW = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [MW:0]    a_i,
  input  logic signed [MW:0]    b_i,
  output logic                  done_o,
  output logic signed [2*MW+1:0] p_o
);

  logic [MW-1:0]   amag, bmag;
  logic [2*MW-1:0] acc_q, am_q;
  logic [MW-1:0]   bm_q;
  logic            neg_q, busy_q;

  // take operand magnitudes
  assign amag = a_i[MW] ? MW'(-a_i) : MW'(a_i);
  assign bmag = b_i[MW] ? MW'(-b_i) : MW'(b_i);

  assign done_o = busy_q && (bm_q == '0);

  // busy from start until the multiplier bits run out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // shift and add one bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      am_q  <= (2*MW)'(amag);
      bm_q  <= bmag;
      neg_q <= a_i[MW] ^ b_i[MW];
    end else if (busy_q && (bm_q != '0)) begin
      if (bm_q[0]) begin
        acc_q <= acc_q + am_q;
      end
      am_q <= am_q << 1;
      bm_q <= bm_q >> 1;
    end
  end

  // apply the sign
  assign p_o = neg_q ? -$signed({2'b00, acc_q}) : $signed({2'b00, acc_q});

endmodule

// ===== design/rrsc_div.sv =====
// ----------------------------------------------------------------------------
// rrsc_div: restoring divider, one quotient bit per cycle
// Produces min(num / den, 2^DIV_QB - 1) for a nonzero den.
// ----------------------------------------------------------------------------
module rrsc_div #(
  parameter int DW = 161
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DW-1:0]               num_i,
  input  logic [DW-1:0]               den_i,
  output logic                        done_o,
  output logic [rrsc_pkg::DIV_QB-1:0] quo_o
);

  localparam int QB = rrsc_pkg::DIV_QB;
  localparam int CW = $clog2(QB);

  logic [DW-1:0] rem_q, den_q;
  logic [QB-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, sat_q;
  logic          ge, last;

  assign ge   = rem_q >= den_q;
  assign last = cnt_q == CW'(QB - 1);

  // hold busy until the last quotient bit, flag the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // subtract the shifted divisor where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i << (QB - 1);
      sat_q <= num_i >= (den_i << QB);
      quo_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - den_q;
      end
      quo_q <= {quo_q[QB-2:0], ge};
      den_q <= den_q >> 1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? '1 : quo_q;

endmodule

// ===== design/rrsc_sqrt.sv =====
// ----------------------------------------------------------------------------
// rrsc_sqrt: integer square root, one result bit per cycle
// Tries each bit from the top and keeps it while the square stays in range.
// ----------------------------------------------------------------------------
module rrsc_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [2*rrsc_pkg::ROOT_BITS-1:0] rad_i,
  output logic                           done_o,
  output logic [rrsc_pkg::ROOT_BITS-1:0] root_o
);

  localparam int RB = rrsc_pkg::ROOT_BITS;

  logic [2*RB-1:0] rad_q, sq;
  logic [RB-1:0]   root_q, bit_q, cand;
  logic            busy_q, done_q;

  assign cand = root_q | bit_q;
  assign sq   = (2*RB)'(cand) * (2*RB)'(cand);

  // run until the lowest bit is tried
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  // keep the trial bit when its square fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      bit_q  <= {1'b1, {(RB-1){1'b0}}};
    end else if (busy_q) begin
      if (sq <= rad_q) begin
        root_q <= cand;
      end
      bit_q <= bit_q >> 1;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== design/rrsc_checker.sv =====
// ----------------------------------------------------------------------------
// rrsc_checker: port-level checks for the running regression unit
// Watches the result channel for handshake and value consistency.
// ----------------------------------------------------------------------------
module rrsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] slope_o,
  input logic               slope_valid_o,
  input logic signed [15:0] correlation_o,
  input logic               correlation_valid_o
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // zero slope without a valid denominator
  a_slope_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slope_valid_o |-> slope_o == 32'sd0)
    else $error("slope nonzero while invalid");

  // zero correlation without a valid denominator
  a_corr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !correlation_valid_o |-> correlation_o == 16'sd0)
    else $error("correlation nonzero while invalid");

  // correlation stays within plus or minus one
  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (correlation_o <= 16'sd16384) && (correlation_o >= -16'sd16384))
    else $error("correlation out of range");

  // a valid correlation needs a valid slope denominator
  a_corr_implies_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && correlation_valid_o |-> slope_valid_o)
    else $error("correlation valid without slope valid");

endmodule

bind running_regression_slope_corr_unit rrsc_checker u_rrsc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .slope_o             (slope_o),
  .slope_valid_o       (slope_valid_o),
  .correlation_o       (correlation_o),
  .correlation_valid_o (correlation_valid_o)
);
